// File: design/cpoc_pkg.sv
package cpoc_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = 2;
  localparam int unsigned ClassBits = 2;

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [ClassBits-1:0] class_t;

  localparam class_t ClassAtomic    = 2'd0;
  localparam class_t ClassOneSided  = 2'd1;
  localparam class_t ClassBilateral = 2'd2;

  localparam count_t CountCap = 2'd2;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

  function automatic class_t pair_class_of(input count_t wa, input count_t wb);
    class_t c;
    if (wa >= CountCap && wb >= CountCap) c = ClassBilateral;
    else if (wa >= CountCap || wb >= CountCap) c = ClassOneSided;
    else c = ClassAtomic;
    return c;
  endfunction

endpackage

// File: design/coprime_pair_omega_classifier_core.sv
// Channel | Dir | tdata fields (low bit up)                              | tuser
// s_axis  | in  | first_value[31:0], second_value[63:32]                 | -
// m_axis  | out | common_divisor[31:0], first_cofactor[63:32],           | -
//         |     | second_cofactor[95:64], first_prime_count[97:96],      |
//         |     | second_prime_count[99:98], pair_class[101:100], 0 pad  |
//
// Every division goes through one shared restoring divider (issue, load,
// one bit step per quotient bit, consume). The gcd takes one division per
// Euclid step, the cofactors one each, and trial division up to the square
// root of each cofactor up to about 33k divisions.
// Reset is synchronous and clears the sequencer and the output valid.
// The block takes a new item whenever the sequencer is idle; a finished
// result waits in S_OUT while an earlier stalled result holds in the output
// register.
module coprime_pair_omega_classifier_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // first_value, second_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // common_divisor, first_cofactor,
                                      // second_cofactor, first_prime_count,
                                      // second_prime_count, pair_class, pad
);
  import cpoc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_GCD     = 10'b0000000010,
    S_COF     = 10'b0000000100,
    S_OM_INIT = 10'b0000001000,
    S_OM_TWO  = 10'b0000010000,
    S_OM_TRY  = 10'b0000100000,
    S_OM_DIV  = 10'b0001000000,
    S_OM_FIN  = 10'b0010000000,
    S_WAIT    = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t   state;
  logic     wait_busy;
  value_t   xv, yv, gx, gy;
  value_t   ca, cb;
  logic     cof_second;
  logic     om_second;
  value_t   n, p;
  count_t   cnt, wa;
  div_req_t req;
  div_rsp_t rsp;

  cpoc_divider u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      req.start     <= 1'b0;
      wait_busy     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            xv    <= s_axis_tdata[31:0];
            yv    <= s_axis_tdata[63:32];
            gx    <= s_axis_tdata[31:0];
            gy    <= s_axis_tdata[63:32];
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // Euclid: advance while the divisor side is nonzero.
          if (wait_busy) begin
            req.start <= 1'b0;
            if (rsp.done) begin
              gx <= gy;
              gy <= rsp.remainder;
              wait_busy <= 1'b0;
            end
          end else if (gy == '0) begin
            if (gx == '0) begin
              ca <= '0; cb <= '0;
              state <= S_OM_INIT; om_second <= 1'b0;
            end else begin
              cof_second <= 1'b0;
              state <= S_COF;
            end
          end else begin
            req.start <= 1'b1; req.dividend <= gx; req.divisor <= gy;
            wait_busy <= 1'b1;
          end
        end
        S_COF: begin
          if (wait_busy) begin
            req.start <= 1'b0;
            if (rsp.done) begin
              wait_busy <= 1'b0;
              if (cof_second) begin
                cb <= rsp.quotient;
                om_second <= 1'b0;
                state <= S_OM_INIT;
              end else begin
                ca <= rsp.quotient;
                cof_second <= 1'b1;
              end
            end
          end else begin
            req.start <= 1'b1;
            req.dividend <= cof_second ? yv : xv;
            req.divisor <= gx;
            wait_busy <= 1'b1;
          end
        end
        S_OM_INIT: begin
          n     <= om_second ? cb : ca;
          cnt   <= '0;
          p     <= ValueBits'(3);
          state <= S_OM_TWO;
        end
        S_OM_TWO: begin
          // Strip factors of two, counted once.
          if (n < ValueBits'(2)) begin
            state <= S_OM_FIN;
          end else if (!n[0]) begin
            cnt <= CountCap - 1'b1;
            n   <= n >> 1;
          end else begin
            state <= S_OM_TRY;
          end
        end
        S_OM_TRY: begin
          // Test p <= n / p via the divider quotient.
          if (wait_busy) begin
            req.start <= 1'b0;
            if (rsp.done) begin
              wait_busy <= 1'b0;
              if (p > rsp.quotient) begin
                state <= S_OM_FIN;
              end else if (rsp.remainder != '0) begin
                p <= p + ValueBits'(2);
              end else if (cnt != '0) begin
                cnt <= CountCap;
                state <= S_OM_FIN;
              end else begin
                cnt   <= cnt + 1'b1;
                n     <= rsp.quotient;
                state <= S_OM_DIV;
              end
            end
          end else begin
            req.start <= 1'b1; req.dividend <= n; req.divisor <= p;
            wait_busy <= 1'b1;
          end
        end
        S_OM_DIV: begin
          // Drop further powers of p.
          if (wait_busy) begin
            req.start <= 1'b0;
            if (rsp.done) begin
              wait_busy <= 1'b0;
              if (rsp.remainder == '0) n <= rsp.quotient;
              else begin
                p <= p + ValueBits'(2);
                state <= S_OM_TRY;
              end
            end
          end else begin
            req.start <= 1'b1; req.dividend <= n; req.divisor <= p;
            wait_busy <= 1'b1;
          end
        end
        S_OM_FIN: begin
          if (cnt < CountCap && n > ValueBits'(1)) begin
            if (om_second) cnt <= cnt + 1'b1; else wa <= cnt + 1'b1;
          end else if (!om_second) wa <= cnt;
          if (om_second) state <= S_WAIT;
          else begin
            om_second <= 1'b1;
            state <= S_OM_INIT;
          end
        end
        S_WAIT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tdata  <= {2'b00, pair_class_of(wa, cnt), cnt, wa, cb, ca, gx};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/cpoc_divider.sv
module cpoc_divider (
  input  logic               clk,
  input  logic               rst,
  input  cpoc_pkg::div_req_t req,
  output cpoc_pkg::div_rsp_t rsp
);
  import cpoc_pkg::*;

  localparam int unsigned CntBits = $clog2(ValueBits + 1);

  logic [CntBits-1:0] cnt;
  logic               busy;
  logic               done;
  value_t             quo;
  value_t             divisor;
  logic [ValueBits:0] rem;
  logic [ValueBits:0] trial;
  logic [ValueBits:0] shifted;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem[ValueBits-1:0], quo[ValueBits-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == CntBits'(1));
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= CntBits'(ValueBits);
        quo     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        if (trial[ValueBits]) begin
          rem <= shifted;
          quo <= {quo[ValueBits-2:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[ValueBits-2:0], 1'b1};
        end
        cnt <= cnt - CntBits'(1);
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[ValueBits-1:0];

endmodule

// File: design/cpoc_checker.sv
module cpoc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_class: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[101:100] != 2'd3) else $error("bad class");
  a_no_immediate: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result without work");
endmodule

bind coprime_pair_omega_classifier_core cpoc_checker u_cpoc_checker (.*);

// File: sim/tb_top.sv
module tb_top;
  import cpoc_pkg::*;

  typedef struct {
    value_t divisor;
    value_t cof_a;
    value_t cof_b;
    count_t cnt_a;
    count_t cnt_b;
    class_t cls;
  } pair_result_t;

  // Keeps the results still owed by the block and compares each returned one.
  class pair_scoreboard;
    pair_result_t owed[$];
    int           mismatches;

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    // Distinct prime factors, counting stops at two.
    function automatic count_t omega_capped(longint unsigned n);
      int unsigned     cnt;
      longint unsigned p;
      cnt = 0;
      if (n < 2) return count_t'(0);
      if (n[0] == 1'b0) begin
        cnt++;
        while (n[0] == 1'b0) n = n >> 1;
      end
      for (p = 3; p <= n / p; p += 2) begin
        if (n % p != 0) continue;
        cnt++;
        if (cnt >= 2) return CountCap;
        do n = n / p; while (n % p == 0);
      end
      if (n > 1) cnt++;
      return (cnt > 2) ? CountCap : count_t'(cnt);
    endfunction

    function automatic void note_pair(value_t x, value_t y);
      pair_result_t    r;
      longint unsigned g;
      g = euclid(x, y);
      r.divisor = value_t'(g);
      r.cof_a   = (g != 0) ? value_t'(x / g) : '0;
      r.cof_b   = (g != 0) ? value_t'(y / g) : '0;
      r.cnt_a   = omega_capped(r.cof_a);
      r.cnt_b   = omega_capped(r.cof_b);
      if (r.cnt_a >= CountCap && r.cnt_b >= CountCap) r.cls = ClassBilateral;
      else if (r.cnt_a >= CountCap || r.cnt_b >= CountCap) r.cls = ClassOneSided;
      else r.cls = ClassAtomic;
      owed = {owed, r};
    endfunction

    function automatic void check_result(logic [103:0] d);
      pair_result_t e;
      bit           bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      e   = owed.pop_front();
      bad = (d[31:0] !== e.divisor) || (d[63:32] !== e.cof_a) ||
            (d[95:64] !== e.cof_b) || (d[97:96] !== e.cnt_a) ||
            (d[99:98] !== e.cnt_b) || (d[101:100] !== e.cls);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp g=%h a=%h b=%h wa=%0d wb=%0d cls=%0d, got %h",
                   e.divisor, e.cof_a, e.cof_b, e.cnt_a, e.cnt_b, e.cls, d);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  pair_scoreboard sb = new();
  int  results_seen = 0;
  bit  calm_sender = 1'b0;

  always #4 clk = ~clk;

  coprime_pair_omega_classifier_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  task automatic offer_pair(value_t x, value_t y);
    int gap;
    gap = 0;
    if (!calm_sender && $urandom_range(99) < 36) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pair(x, y);
  endtask

  task automatic offer_random_pair();
    int unsigned a, b, big;
    value_t      g;
    if ($urandom_range(99) < 20) begin
      offer_pair($urandom_range(1, 65535), $urandom_range(1, 65535));
    end else begin
      // Large common part, small cofactors: wide values, short trial division.
      a   = $urandom_range(1, 4095);
      b   = $urandom_range(1, 4095);
      big = (a > b) ? a : b;
      g   = $urandom_range(1, 32'hFFFF_FFFF / big);
      offer_pair(g * a, g * b);
    end
  endtask

  // Receiver: random stalls, one long hold-off after the twentieth result.
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        results_seen++;
        if (results_seen == 20) hold = 20000;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (results_seen >= 50 && results_seen < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    offer_pair(32'd1, 32'd1);
    offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_pair(32'hFFFF_FFFF, 32'd1);
    offer_pair(32'd1, 32'hFFFF_FFFF);
    offer_pair(32'h8000_0000, 32'h8000_0000);
    offer_pair(32'h8000_0000, 32'd1);
    offer_pair(32'h8000_0000, 32'hC000_0000);
    offer_pair(32'd6, 32'd35);
    offer_pair(32'd12, 32'd18);
    offer_pair(32'd30, 32'd7);
    offer_pair(32'd2, 32'd3);
    offer_pair(32'd4, 32'd4);
    offer_pair(32'd15, 32'd1);
    offer_pair(32'd49, 32'd121);
    offer_pair(32'd210, 32'd1001);
    offer_pair(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    offer_pair(32'd97, 32'd89);
    for (int i = 0; i < 85; i++) begin
      calm_sender = (i >= 40 && i < 60);
      if (i == 70) begin
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
      end
      offer_random_pair();
    end
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("tb_top failed");
    $finish;
  end
endmodule
